FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the chain walker.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define FCW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("chain walker assertion failed");

// Concurrent assertion that is also checked during reset.
`define FCW_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("chain walker assertion failed during reset");

`endif

FILE: rtl/fcw_pkg.sv
// Package of the cluster chain walker: action codes, defaults and shared types.
// Used by every module of the block but fcw_fifo; depends on nothing.
`timescale 1ns / 1ps

package fcw_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int JOB_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF    = 2;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic [2:0] ACT_DATA       = 3'd0;
  localparam logic [2:0] ACT_FAT        = 3'd1;
  localparam logic [2:0] ACT_EOC        = 3'd2;
  localparam logic [2:0] ACT_BAD        = 3'd3;
  localparam logic [2:0] ACT_CORRUPT    = 3'd4;
  localparam logic [2:0] ACT_UNEXPECTED = 3'd5;

  localparam logic [1:0] CMD_OPEN    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_ENTRY   = 2'd2;

  localparam logic [1:0] REG_FAT16    = 2'd0;
  localparam logic [1:0] REG_SPC      = 2'd1;
  localparam logic [1:0] REG_FAT_LBA  = 2'd2;
  localparam logic [1:0] REG_DATA_LBA = 2'd3;

  localparam logic [31:0] EOC16 = 32'h0000_FFFF;
  localparam logic [31:0] BAD16 = 32'h0000_FFF8;
  localparam logic [31:0] EOC32 = 32'hFFFF_FFFF;
  localparam logic [31:0] BAD32 = 32'hFFFF_FFF8;

  typedef struct packed {
    logic        fat16_mode;
    logic [7:0]  sectors_per_cluster;
    logic [31:0] fat_begin_lba;
    logic [31:0] data_begin_lba;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] cluster;
    logic [7:0]  sector_index;
  } job_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] block_address;
    logic [8:0]  entry_byte_pos;
  } res_t;

endpackage

FILE: rtl/fcw_fifo.sv
// Small register queue used between the front and back and at the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module fcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

FILE: rtl/fcw_front.sv
// Front of the chain walker: holds the walk state and classifies each command.
// Depends on fcw_pkg; feeds jobs into the queue in front of fcw_back.
`timescale 1ns / 1ps

module fcw_front
  import fcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [31:0] cluster,
  input  logic [31:0] fat_entry,
  output logic        job_push,
  output job_t        job,
  input  logic        job_full
);

  logic [31:0] current_cluster;
  logic [31:0] current_cluster_next;
  logic [7:0]  sector_in_cluster;
  logic [7:0]  sector_in_cluster_next;
  logic        awaiting_entry;
  logic        awaiting_entry_next;
  logic [31:0] entry;
  logic [31:0] eoc;
  logic [31:0] bad;

  assign full     = job_full;
  assign job_push = push && !job_full;

  always_comb begin
    entry = cfg.fat16_mode ? {16'h0000, fat_entry[15:0]} : fat_entry;
    eoc   = cfg.fat16_mode ? EOC16 : EOC32;
    bad   = cfg.fat16_mode ? BAD16 : BAD32;

    current_cluster_next   = current_cluster;
    sector_in_cluster_next = sector_in_cluster;
    awaiting_entry_next    = awaiting_entry;
    job.action       = ACT_UNEXPECTED;
    job.cluster      = current_cluster;
    job.sector_index = 8'd0;

    case (cmd)
      CMD_OPEN: begin
        current_cluster_next   = cluster;
        sector_in_cluster_next = 8'd1;
        awaiting_entry_next    = 1'b0;
        job.action  = ACT_DATA;
        job.cluster = cluster;
      end
      CMD_ADVANCE: begin
        if (awaiting_entry) begin
          job.action = ACT_UNEXPECTED;
        end else if (sector_in_cluster != cfg.sectors_per_cluster) begin
          job.action             = ACT_DATA;
          job.sector_index       = sector_in_cluster;
          sector_in_cluster_next = sector_in_cluster + 8'd1;
        end else begin
          job.action          = ACT_FAT;
          awaiting_entry_next = 1'b1;
        end
      end
      CMD_ENTRY: begin
        if (awaiting_entry) begin
          awaiting_entry_next = 1'b0;
          if (entry == eoc) begin
            job.action = ACT_EOC;
          end else if (entry >= bad) begin
            job.action = ACT_BAD;
          end else if (entry == 32'd0) begin
            job.action = ACT_CORRUPT;
          end else begin
            current_cluster_next   = entry;
            sector_in_cluster_next = 8'd1;
            job.action  = ACT_DATA;
            job.cluster = entry;
          end
        end
      end
      default: begin
        job.action = ACT_UNEXPECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_cluster   <= '0;
      sector_in_cluster <= '0;
      awaiting_entry    <= 1'b0;
    end else if (job_push) begin
      current_cluster   <= current_cluster_next;
      sector_in_cluster <= sector_in_cluster_next;
      awaiting_entry    <= awaiting_entry_next;
    end
  end

endmodule

FILE: rtl/fcw_back.sv
// Back of the chain walker: turns a queued job into block address and position.
// Depends on fcw_pkg; reads jobs from the front queue, writes the result queue.
`timescale 1ns / 1ps

module fcw_back
  import fcw_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  cfg_t  cfg,
  input  job_t  job,
  input  logic  job_empty,
  output logic  job_pop,
  output logic  res_push,
  output res_t  res,
  input  logic  res_full
);

  localparam int SB_LOG = $clog2(SECTOR_BYTES);

  logic [31:0] rel;
  logic [39:0] prod;
  logic [39:0] data_sum;
  logic [33:0] offset;
  logic [31:0] fat_blk;

  assign job_pop  = !job_empty && !res_full;
  assign res_push = job_pop;

  always_comb begin
    rel      = job.cluster - 32'd2;
    prod     = {8'd0, rel} * {32'd0, cfg.sectors_per_cluster};
    data_sum = {8'd0, cfg.data_begin_lba} + prod + {32'd0, job.sector_index};
    offset   = cfg.fat16_mode ? {1'b0, job.cluster, 1'b0} : {job.cluster, 2'b00};
    fat_blk  = cfg.fat_begin_lba + 32'(offset >> SB_LOG);

    res.action         = job.action;
    res.block_address  = 32'd0;
    res.entry_byte_pos = 9'd0;
    case (job.action)
      ACT_DATA: begin
        res.block_address = data_sum[31:0];
      end
      ACT_FAT: begin
        res.block_address  = fat_blk;
        res.entry_byte_pos = offset[8:0];
      end
      default: begin
        res.block_address  = 32'd0;
        res.entry_byte_pos = 9'd0;
      end
    endcase
  end

endmodule

FILE: rtl/fat_cluster_chain_walker_top.sv
// Top level of the FAT16/FAT32 cluster chain walker: registers, front, queues, back.
// Depends on fcw_pkg, fcw_front, fcw_fifo and fcw_back.
//
//   Channel   Handshake              Payload
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//   command   push / full            cmd, cluster, fat_entry
//   result    empty / pop            action, block_address, entry_byte_pos
//
// One command is taken per cycle while full is low; its result reaches the result
// ports through the job queue register and then the result queue register.
// The job queue is written in the push cycle, the back computes the address
// with one 32x8 multiply-add and writes the result queue, which is read directly.
// full rises only when the job queue fills, i.e. when pop stays low for a while.
// Synchronous reset empties both queues and loads the reset register values.
`timescale 1ns / 1ps

module fat_cluster_chain_walker_top
  import fcw_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int JOB_DEPTH    = JOB_DEPTH_DEF,
  parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [31:0]       cluster,
  input  logic [31:0]       fat_entry,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        action,
  output logic [31:0]       block_address,
  output logic [8:0]        entry_byte_pos
);

  cfg_t        cfg;
  job_t        job_in;
  job_t        job_out;
  res_t        res_in;
  res_t        res_out;
  logic        job_push;
  logic        job_full;
  logic        job_pop;
  logic        job_empty;
  logic        res_push;
  logic        res_full;
  logic        cfg_write;
  logic [1:0]  reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat16_mode          <= 1'b0;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.fat_begin_lba       <= '0;
      cfg.data_begin_lba      <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_FAT16:    cfg.fat16_mode          <= pwdata[0];
        REG_SPC:      cfg.sectors_per_cluster <= pwdata[7:0];
        REG_FAT_LBA:  cfg.fat_begin_lba       <= pwdata;
        REG_DATA_LBA: cfg.data_begin_lba      <= pwdata;
        default:      cfg.fat16_mode          <= cfg.fat16_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_FAT16:    prdata = {31'd0, cfg.fat16_mode};
      REG_SPC:      prdata = {24'd0, cfg.sectors_per_cluster};
      REG_FAT_LBA:  prdata = cfg.fat_begin_lba;
      REG_DATA_LBA: prdata = cfg.data_begin_lba;
      default:      prdata = '0;
    endcase
  end

  fcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cluster   (cluster),
    .fat_entry (fat_entry),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  fcw_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  fcw_back #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .cfg       (cfg),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  fcw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign action         = res_out.action;
  assign block_address  = res_out.block_address;
  assign entry_byte_pos = res_out.entry_byte_pos;

endmodule

FILE: rtl/fcw_checker.sv
// Port-level checker of the chain walker and the bind that attaches it.
// Depends on fcw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcw_checker
  import fcw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input logic [2:0]        action,
  input logic [31:0]       block_address,
  input logic [8:0]        entry_byte_pos
);

  logic addr_act;
  logic no_payload;

  assign addr_act   = (action == ACT_DATA) || (action == ACT_FAT);
  assign no_payload = (block_address == 32'd0) && (entry_byte_pos == 9'd0);

  `FCW_ASSERT_RST(a_empty_after_reset, clk, rst |=> empty)
  `FCW_ASSERT(a_action_known, clk, rst, !empty |-> action <= ACT_UNEXPECTED)
  `FCW_ASSERT(a_status_no_address, clk, rst, (!empty && !addr_act) |-> no_payload)
  `FCW_ASSERT(a_data_no_pos, clk, rst, (!empty && action == ACT_DATA) |-> entry_byte_pos == 9'd0)
  `FCW_ASSERT(a_result_held, clk, rst, (!empty && !pop) |=> (!empty && $stable(block_address)))

endmodule

bind fat_cluster_chain_walker_top fcw_checker u_fcw_checker (.*);
